// ----- rtl/core/smvtp_pkg.sv -----
// shared types and constants of the sampled min-vtime task picker
package smvtp_pkg;

  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_DISP = 2'd1;
  localparam logic [1:0] KIND_RUN  = 2'd2;
  localparam logic [1:0] KIND_STOP = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_PICK  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic [1:0] CFG_SLICE  = 2'd0;
  localparam logic [1:0] CFG_BUDGET = 2'd1;
  localparam logic [1:0] CFG_SEED   = 2'd2;

  localparam logic [31:0] LFSR_MASK     = 32'h8020_0003;
  localparam logic [31:0] SLICE_RESET   = 32'd20000000;
  localparam logic [9:0]  BUDGET_RESET  = 10'd500;
  localparam logic [31:0] SEED_RESET    = 32'd1;
  localparam logic [6:0]  CHARGE_SCALE  = 7'd100;

  typedef struct packed {
    logic [1:0]  kind;
    logic [21:0] task_id;
    logic [63:0] task_vtime;
    logic [31:0] slice_left;
    logic [13:0] weight;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [21:0] picked_id;
    logic [63:0] charged_vtime;
    logic [63:0] now_vtime;
    logic        last;
  } out_item_t;

endpackage

// ----- rtl/core/smvtp_front.sv -----
// front end: input register stage that holds one pending transaction for the back end
module smvtp_front import smvtp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     q_valid_o,
  input  logic     q_take_i,
  output in_item_t q_data_o
);
  logic     full_q;
  in_item_t data_q;

  assign in_stall_o = full_q;
  assign q_valid_o  = full_q;
  assign q_data_o   = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (!full_q && in_valid_i) begin
      full_q <= 1'b1;
    end else if (q_take_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!full_q && in_valid_i) begin
      data_q <= in_data_i;
    end
  end
endmodule

// ----- rtl/core/smvtp_divider.sv -----
// radix-2 restoring divider, 64 by 14 bits, one quotient bit per cycle
module smvtp_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [13:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [63:0] quot_q;
  logic [13:0] rem_q;
  logic [13:0] div_q;
  logic [14:0] trial;

  assign trial  = {rem_q, quot_q[63]} - {1'b0, div_q};
  assign done_o = busy_q && (cnt_q == 7'd0);
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 7'd64;
    end else if (busy_q) begin
      if (cnt_q == 7'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q && cnt_q != 7'd0) begin
      if (!trial[14]) begin
        rem_q  <= trial[13:0];
        quot_q <= {quot_q[62:0], 1'b1};
      end else begin
        rem_q  <= {rem_q[12:0], quot_q[63]};
        quot_q <= {quot_q[62:0], 1'b0};
      end
    end
  end
endmodule

// ----- rtl/core/smvtp_modcnt.sv -----
// 32-bit by count modulo unit, one remainder bit per cycle
module smvtp_modcnt #(
  parameter int unsigned CW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   value_i,
  input  logic [CW-1:0] count_i,
  output logic          done_o,
  output logic [CW-1:0] rem_o
);
  logic [5:0]    cnt_q;
  logic          busy_q;
  logic [31:0]   val_q;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] div_q;
  logic [CW:0]   shifted;
  logic [CW:0]   trial;

  assign shifted = {rem_q, val_q[31]};
  assign trial   = shifted - {1'b0, div_q};
  assign done_o  = busy_q && (cnt_q == 6'd0);
  assign rem_o   = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd32;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
      rem_q <= '0;
      div_q <= count_i;
    end else if (busy_q && cnt_q != 6'd0) begin
      val_q <= {val_q[30:0], 1'b0};
      if (!trial[CW]) begin
        rem_q <= trial[CW-1:0];
      end else begin
        rem_q <= shifted[CW-1:0];
      end
    end
  end
endmodule

// ----- rtl/core/smvtp_back.sv -----
// back end: task table, sampling loop, clock update and stop charging
module smvtp_back import smvtp_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_take_o,
  input  in_item_t    q_data_i,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_LFSR, S_MOD, S_READ, S_CMP, S_TAILRD, S_TAILWR,
    S_SOLO, S_DIV, S_OUT
  } state_e;

  state_e        state_q;
  logic [31:0]   slice_q;
  logic [9:0]    budget_q;
  logic [31:0]   lfsr_q;
  logic [CW-1:0] count_q;
  logic [63:0]   now_q;
  logic [10:0]   todo_q;
  logic          have_q;
  logic [AW-1:0] best_q;
  logic [63:0]   best_vt_q;
  logic [AW-1:0] key_q;
  logic [21:0]   tail_id_q;
  logic          second_q;
  out_item_t     out_q;
  logic          out_full_q;

  logic [21:0] id_mem [TABLE_DEPTH];
  logic [63:0] vt_mem [TABLE_DEPTH];
  logic [21:0] rd_id_q;
  logic [63:0] rd_vt_q;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [21:0] wr_id;
  logic [63:0] wr_vt;

  logic          mod_start, mod_done;
  logic [CW-1:0] mod_rem;
  logic          div_start, div_done;
  logic [63:0]   div_quot;

  logic [31:0] lfsr_nx;
  logic [63:0] floor_vt;
  logic [63:0] used;
  logic [13:0] wt;
  logic [10:0] samples;
  logic [10:0] cnt_p1;
  logic        budget_gt;
  logic [63:0] run_diff;
  logic [63:0] enq_diff;

  assign lfsr_nx  = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);
  assign floor_vt = now_q - {32'd0, slice_q};
  assign enq_diff = q_data_i.task_vtime - floor_vt;
  assign run_diff = now_q - q_data_i.task_vtime;
  assign used     = (q_data_i.slice_left < slice_q) ?
                    {32'd0, slice_q - q_data_i.slice_left} : 64'd0;
  assign wt       = (q_data_i.weight == 14'd0) ? 14'd1 : q_data_i.weight;
  // count+1 is only taken when count is below the budget, so it fits 11 bits
  assign cnt_p1    = 11'(count_q) + 11'd1;
  assign budget_gt = (32'(budget_q) > 32'(count_q));
  assign samples   = (budget_q == 10'd0) ? 11'd1 :
                     (budget_gt ? cnt_p1 : {1'b0, budget_q});

  assign out_valid_o = out_full_q;
  assign out_data_o  = out_q;

  // the modulo unit starts on the stepped lfsr value
  smvtp_modcnt #(.CW(CW)) u_mod (
    .clk_i, .rst_ni, .start_i(mod_start), .value_i(lfsr_nx), .count_i(count_q),
    .done_o(mod_done), .rem_o(mod_rem)
  );

  // used*100 fits in 39 bits, so the divider input is narrow in practice
  smvtp_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i(used * {57'd0, CHARGE_SCALE}), .divisor_i(wt),
    .done_o(div_done), .quot_o(div_quot)
  );

  // table memory
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      id_mem[wr_addr] <= wr_id;
      vt_mem[wr_addr] <= wr_vt;
    end
    if (rd_en) begin
      rd_id_q <= id_mem[rd_addr];
      rd_vt_q <= vt_mem[rd_addr];
    end
  end

  logic idle_free;
  assign idle_free = (state_q == S_IDLE) && q_valid_i && !out_full_q;

  always_comb begin
    q_take_o  = 1'b0;
    mod_start = (state_q == S_LFSR);
    div_start = idle_free && q_data_i.kind == KIND_STOP;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_id     = q_data_i.task_id;
    wr_vt     = enq_diff[63] ? floor_vt : q_data_i.task_vtime;
    case (state_q)
      S_IDLE: begin
        if (idle_free) begin
          // stopping keeps its transaction until the charge is posted
          q_take_o = (q_data_i.kind != KIND_STOP);
          if (q_data_i.kind == KIND_ENQ && count_q < DEPTH_C) begin
            wr_en   = 1'b1;
            wr_addr = AW'(count_q);
          end
          if (q_data_i.kind == KIND_DISP) begin
            rd_en    = 1'b1;
            rd_addr  = '0;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          rd_en   = 1'b1;
          rd_addr = AW'(mod_rem);
        end
      end
      S_TAILRD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(count_q - CW'(1));
      end
      S_TAILWR: begin
        wr_en   = 1'b1;
        wr_addr = best_q;
        wr_id   = rd_id_q;
        wr_vt   = rd_vt_q;
      end
      S_OUT: begin
        // entry 0 after the swap, for a lone survivor
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_DIV: begin
        q_take_o = div_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      slice_q    <= SLICE_RESET;
      budget_q   <= BUDGET_RESET;
      lfsr_q     <= SEED_RESET;
      count_q    <= '0;
      now_q      <= '0;
      out_full_q <= 1'b0;
      todo_q     <= '0;
      have_q     <= 1'b0;
      second_q   <= 1'b0;
      best_q     <= '0;
      best_vt_q  <= '0;
      key_q      <= '0;
      tail_id_q  <= '0;
      out_q      <= '0;
    end else begin
      if (out_full_q && !out_stall_i) begin
        out_full_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SLICE:  slice_q  <= cfg_data_i;
          CFG_BUDGET: budget_q <= cfg_data_i[9:0];
          CFG_SEED:   lfsr_q   <= cfg_data_i;
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (idle_free) begin
            case (q_data_i.kind)
              KIND_ENQ: begin
                out_full_q <= 1'b1;
                if (count_q < DEPTH_C) begin
                  count_q <= count_q + CW'(1);
                  out_q <= '{status: ST_DONE, picked_id: '0, charged_vtime: '0,
                             now_vtime: now_q, last: 1'b1};
                end else begin
                  out_q <= '{status: ST_FULL, picked_id: '0, charged_vtime: '0,
                             now_vtime: now_q, last: 1'b1};
                end
              end
              KIND_DISP: begin
                if (count_q == '0) begin
                  out_full_q <= 1'b1;
                  out_q <= '{status: ST_EMPTY, picked_id: '0, charged_vtime: '0,
                             now_vtime: now_q, last: 1'b1};
                end else if (count_q == CW'(1)) begin
                  state_q <= S_SOLO;
                end else begin
                  todo_q  <= samples;
                  have_q  <= 1'b0;
                  state_q <= S_LFSR;
                end
              end
              KIND_RUN: begin
                out_full_q <= 1'b1;
                if (run_diff[63]) begin
                  now_q <= q_data_i.task_vtime;
                  out_q <= '{status: ST_DONE, picked_id: '0, charged_vtime: '0,
                             now_vtime: q_data_i.task_vtime, last: 1'b1};
                end else begin
                  out_q <= '{status: ST_DONE, picked_id: '0, charged_vtime: '0,
                             now_vtime: now_q, last: 1'b1};
                end
              end
              default: begin
                state_q <= S_DIV;
              end
            endcase
          end
        end
        S_LFSR: begin
          // lfsr steps here; the modulo unit starts on the same new value
          lfsr_q  <= lfsr_nx;
          state_q <= S_MOD;
        end
        S_MOD: begin
          if (mod_done) begin
            key_q   <= AW'(mod_rem);
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (!have_q || rd_vt_q < best_vt_q) begin
            best_vt_q <= rd_vt_q;
            best_q    <= key_q;
            tail_id_q <= rd_id_q;
            have_q    <= 1'b1;
          end
          todo_q <= todo_q - 11'd1;
          if (todo_q == 11'd1) begin
            state_q <= S_TAILRD;
          end else begin
            state_q <= S_LFSR;
          end
        end
        S_TAILRD: begin
          state_q <= S_TAILWR;
        end
        S_TAILWR: begin
          count_q  <= count_q - CW'(1);
          second_q <= (count_q == CW'(2));
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (!out_full_q) begin
            out_full_q <= 1'b1;
            out_q <= '{status: ST_PICK, picked_id: tail_id_q, charged_vtime: '0,
                       now_vtime: now_q, last: !second_q};
            state_q <= second_q ? S_SOLO : S_IDLE;
          end
        end
        S_SOLO: begin
          if (!out_full_q) begin
            out_full_q <= 1'b1;
            count_q    <= '0;
            out_q <= '{status: ST_PICK, picked_id: rd_id_q, charged_vtime: '0,
                       now_vtime: now_q, last: 1'b1};
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            out_full_q <= 1'b1;
            out_q <= '{status: ST_DONE, picked_id: '0,
                       charged_vtime: q_data_i.task_vtime + div_quot,
                       now_vtime: now_q, last: 1'b1};
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/core/sampled_min_vtime_task_picker.sv -----
// top level of the sampled min-vtime task picker
// enqueue, running: result registered behind the input register when the output is free
// stopping: charge from the 64-step divider, input held until the charge is posted
// dispatch: per sample lfsr step, 32-step modulo by live count, table read, compare;
//   min(budget, count+1) samples, at least 1; one transaction is processed at a time
// reset clears count, clock and control; registers return to 20000000, 500, 1
// the table memory is not cleared, only entries below count are ever used
module sampled_min_vtime_task_picker import smvtp_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  logic     q_valid, q_take;
  in_item_t q_data;

  assign cfg_ready_o = 1'b1;

  smvtp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_take_i(q_take), .q_data_o(q_data)
  );

  smvtp_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_take_o(q_take),
    .q_data_i(q_data), .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule

// ----- bench/smvtp_scoreboard.sv -----
// checker for the sampled min-vtime task picker: predicts and compares results
module smvtp_scoreboard import smvtp_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [31:0] slice_q;
  logic [9:0]  budget_q;
  logic [31:0] lfsr_q;
  logic [21:0] tab_id [DEPTH];
  logic [63:0] tab_vt [DEPTH];
  int unsigned tab_cnt;
  logic [63:0] now_q;
  out_item_t   expected_q[$];
  int          fails;

  function automatic logic before_in_time(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    return d[63];
  endfunction

  task automatic push_result(logic [1:0] st, logic [21:0] id, logic [63:0] charged,
                             logic lst);
    out_item_t r;
    r.status        = st;
    r.picked_id     = id;
    r.charged_vtime = charged;
    r.now_vtime     = now_q;
    r.last          = lst;
    expected_q.push_back(r);
  endtask

  task automatic schedule_step(in_item_t it);
    logic [63:0] floor_vt, vt, best_vt, used;
    logic [31:0] key;
    int unsigned samples, best, tail;
    logic [13:0] wt;
    logic [21:0] picked;
    case (it.kind)
      KIND_ENQ: begin
        floor_vt = now_q - {32'd0, slice_q};
        if (tab_cnt >= DEPTH) begin
          push_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          vt = it.task_vtime;
          if (before_in_time(vt, floor_vt)) vt = floor_vt;
          tab_id[tab_cnt] = it.task_id;
          tab_vt[tab_cnt] = vt;
          tab_cnt++;
          push_result(ST_DONE, '0, '0, 1'b1);
        end
      end
      KIND_DISP: begin
        if (tab_cnt == 0) begin
          push_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          if (tab_cnt > 1) begin
            samples = (budget_q == 0) ? 1 : budget_q;
            if (samples > tab_cnt + 1) samples = tab_cnt + 1;
            best = 0;
            best_vt = '0;
            for (int unsigned i = 0; i < samples; i++) begin
              lfsr_q = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_MASK) : (lfsr_q >> 1);
              key = lfsr_q % tab_cnt;
              if (i == 0 || tab_vt[key] < best_vt) begin
                best_vt = tab_vt[key];
                best = key;
              end
            end
            tail = tab_cnt - 1;
            picked = tab_id[best];
            tab_id[best] = tab_id[tail];
            tab_vt[best] = tab_vt[tail];
            tab_cnt = tail;
            push_result(ST_PICK, picked, '0, tab_cnt != 1);
          end
          // a lone survivor goes out right behind the pick
          if (tab_cnt == 1) begin
            tab_cnt = 0;
            push_result(ST_PICK, tab_id[0], '0, 1'b1);
          end
        end
      end
      KIND_RUN: begin
        if (before_in_time(now_q, it.task_vtime)) now_q = it.task_vtime;
        push_result(ST_DONE, '0, '0, 1'b1);
      end
      default: begin
        used = (it.slice_left < slice_q) ? {32'd0, slice_q} - {32'd0, it.slice_left} : '0;
        wt = (it.weight == 0) ? 14'd1 : it.weight;
        push_result(ST_DONE, '0, it.task_vtime + (used * 64'd100) / {50'd0, wt}, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e;
    if (!rst_ni) begin
      slice_q  = SLICE_RESET;
      budget_q = BUDGET_RESET;
      lfsr_q   = SEED_RESET;
      tab_cnt  = 0;
      now_q    = '0;
      expected_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (out_data_i.status !== e.status) begin
            $error("status expected %0d got %0d", e.status, out_data_i.status);
            fails++;
          end
          if (out_data_i.picked_id !== e.picked_id) begin
            $error("picked_id expected %0h got %0h", e.picked_id, out_data_i.picked_id);
            fails++;
          end
          if (out_data_i.charged_vtime !== e.charged_vtime) begin
            $error("charged_vtime expected %0h got %0h", e.charged_vtime,
                   out_data_i.charged_vtime);
            fails++;
          end
          if (out_data_i.now_vtime !== e.now_vtime) begin
            $error("now_vtime expected %0h got %0h", e.now_vtime, out_data_i.now_vtime);
            fails++;
          end
          if (out_data_i.last !== e.last) begin
            $error("last expected %0d got %0d", e.last, out_data_i.last);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SLICE:  slice_q = cfg_data_i;
          CFG_BUDGET: budget_q = cfg_data_i[9:0];
          CFG_SEED:   lfsr_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) schedule_step(in_data_i);
      fail_count_o <= fails;
      pending_o <= expected_q.size();
    end
  end

endmodule

// ----- bench/sampled_min_vtime_task_picker_tb.sv -----
// testbench top: stimulus, stalls, verdict for the sampled min-vtime task picker
module sampled_min_vtime_task_picker_tb import smvtp_pkg::*;;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned LIMIT = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          fail_count, pending;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  int unsigned tab_cnt = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  sampled_min_vtime_task_picker #(.TABLE_DEPTH(DEPTH)) u_top (.*);

  smvtp_scoreboard #(.DEPTH(DEPTH)) u_scoreboard (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("sampled_min_vtime_task_picker_tb: FAIL");
      $finish;
    end
  end

  // receiver stall pattern: modes switch on bits 8:7 of the cycle counter
  always @(posedge clk_i) begin
    case (cycles[8:7])
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(0, 1) == 0);
      2'd2: out_stall_i <= ($urandom_range(0, 9) < 8);
      default: out_stall_i <= cycles[2];
    endcase
  end

  task automatic send(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    // mirror table occupancy so random traffic keeps the table small
    if (it.kind == KIND_ENQ && tab_cnt < DEPTH) tab_cnt++;
    if (it.kind == KIND_DISP) begin
      if (tab_cnt > 1) tab_cnt--;
      if (tab_cnt == 1) tab_cnt = 0;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_item_t make_item(logic [1:0] k, logic [63:0] vt, logic [31:0] left,
                                         logic [13:0] wt, logic [21:0] id);
    in_item_t it;
    it.kind = k;
    it.task_id = id;
    it.task_vtime = vt;
    it.slice_left = left;
    it.weight = wt;
    return it;
  endfunction

  function automatic logic [63:0] rand_vtime();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return {32'd0, $urandom_range(0, 100000)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic in_item_t rand_item();
    logic [1:0] k;
    logic [13:0] wt;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tab_cnt >= 12) k = KIND_DISP;
    else if (r < 35) k = KIND_ENQ;
    else if (r < 65) k = KIND_DISP;
    else if (r < 80) k = KIND_RUN;
    else k = KIND_STOP;
    case ($urandom_range(0, 9))
      0: wt = '0;
      1: wt = 14'($urandom);
      default: wt = 14'($urandom_range(1, 10000));
    endcase
    return make_item(k, rand_vtime(),
                     $urandom_range(0, 1) ? $urandom : $urandom_range(0, 30000000),
                     wt, 22'($urandom));
  endfunction

  task automatic random_phase(int unsigned n);
    repeat (n) send(rand_item());
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty table, field extremes, two-result dispatch, charging corners
    send(make_item(KIND_DISP, '0, '0, 14'd1, '0));
    send(make_item(KIND_ENQ, '1, '0, 14'd1, 22'h3fffff));
    send(make_item(KIND_ENQ, '0, '0, 14'd1, '0));
    send(make_item(KIND_DISP, '0, '0, 14'd1, '0));
    send(make_item(KIND_ENQ, 64'd5, '0, 14'd1, 22'h155555));
    send(make_item(KIND_DISP, '0, '0, 14'd1, '0));
    send(make_item(KIND_RUN, 64'd100000000, '0, 14'd1, '0));
    send(make_item(KIND_ENQ, 64'd3, '0, 14'd1, 22'h2aaaaa));
    send(make_item(KIND_ENQ, 64'd90000000, '0, 14'd1, 22'h000001));
    send(make_item(KIND_ENQ, 64'd85000000, '0, 14'd1, 22'h000002));
    send(make_item(KIND_DISP, '0, '0, 14'd1, '0));
    send(make_item(KIND_DISP, '0, '0, 14'd1, '0));
    send(make_item(KIND_RUN, 64'd5, '0, 14'd1, '0));
    send(make_item(KIND_RUN, 64'h8000_0000_0000_0000, '0, 14'd1, '0));
    send(make_item(KIND_RUN, '1, '0, 14'd1, '0));
    send(make_item(KIND_STOP, '1, '0, 14'd0, '0));
    send(make_item(KIND_STOP, 64'd1000, 32'hffffffff, 14'd1, '0));
    send(make_item(KIND_STOP, 64'd1000, '0, 14'h3fff, '0));
    send(make_item(KIND_STOP, 64'd7, 32'd19999999, 14'd10000, '0));
    drain();

    write_reg(CFG_SLICE, 32'hffffffff);
    write_reg(CFG_BUDGET, 32'd1023);
    write_reg(CFG_SEED, 32'hffffffff);
    write_reg(2'd3, 32'h12345678);
    random_phase(100);

    // fill a batch with minimal sampling, then empty it again
    write_reg(CFG_SLICE, 32'd1);
    write_reg(CFG_BUDGET, 32'd0);
    write_reg(CFG_SEED, 32'd0);
    for (int unsigned i = 0; i < 40; i++)
      send(make_item(KIND_ENQ, rand_vtime(), '0, 14'd1, 22'($urandom)));
    drain();
    write_reg(CFG_BUDGET, 32'd1);
    write_reg(CFG_SEED, $urandom | 32'd1);
    while (tab_cnt > 0) send(make_item(KIND_DISP, '0, '0, 14'd1, '0));
    drain();

    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_SLICE, $urandom_range(0, 1) ? $urandom : $urandom_range(1, 1000));
      write_reg(CFG_BUDGET, $urandom_range(0, 1023));
      write_reg(CFG_SEED, $urandom);
      random_phase(80);
    end

    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("sampled_min_vtime_task_picker_tb: PASS");
    end else begin
      $display("sampled_min_vtime_task_picker_tb: FAIL");
    end
    $finish;
  end

endmodule
